@@ rtl/ran_pkg.sv @@
package ran_pkg;

   localparam int DEF_WORD_BITS = 32;

   // operand widths fixed by the transaction format
   localparam int IN_W   = 32;
   localparam int MAG_IN = 31;
   // raw magnitudes stay below 2^63
   localparam int MAG_W  = 63;
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W  = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_NORM  = 2'd0,
      OP_MUL   = 2'd1,
      OP_ADD   = 2'd2,
      OP_SCALE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_COMBINE,
      S_CHECK,
      S_GCD,
      S_DIVN,
      S_DIVD,
      S_OUT
   } state_type;

endpackage

@@ rtl/rational_arith_normalize.sv @@
// channel   ports               direction   accepted when
// req       req_valid/req_stall into block  req_valid & !req_stall
// rsp       rsp_valid/rsp_stall out of block rsp_valid & !rsp_stall
//
// one transaction at a time; req_stall is high from acceptance until the result
// is loaded into the output register, which may still hold the previous result
// work per transaction: up to three passes through one 32x32 multiplier, the binary
// gcd (one shift, swap or subtract per cycle) and two 63-step divisions; a zero
// numerator or denominator skips the gcd and the divisions
// synchronous active-high reset clears the sequencer and rsp_valid; no clearing pass
module rational_arith_normalize #(
   parameter int WORD_BITS = ran_pkg::DEF_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ran_pkg::op_type      req_op,
   input  logic                 req_a_neg,
   input  logic signed [31:0]   req_a_num,
   input  logic signed [31:0]   req_a_den,
   input  logic                 req_b_neg,
   input  logic        [30:0]   req_b_num,
   input  logic        [30:0]   req_b_den,
   input  logic signed [31:0]   req_scalar,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_res_neg,
   output logic        [30:0]   rsp_res_num,
   output logic        [30:0]   rsp_res_den,
   output ran_pkg::status_type  rsp_status
);
   import ran_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   op_type              op_ff, op_in;
   logic                dn_ff, dn_in;
   logic                bn_ff, bn_in;
   logic                num_neg_ff, num_neg_in;
   logic [IN_W-1:0]     nm_ff, nm_in;
   logic [IN_W-1:0]     dm_ff, dm_in;
   logic [IN_W-1:0]     sm_ff, sm_in;
   logic [MAG_IN-1:0]   bnum_ff, bnum_in;
   logic [MAG_IN-1:0]   bden_ff, bden_in;
   logic [MAG_W-1:0]    num_ff, num_in;
   logic [MAG_W-1:0]    den_ff, den_in;
   logic [MAG_W-1:0]    m2_ff, m2_in;
   logic [MAG_W-1:0]    x_ff, x_in;
   logic [MAG_W-1:0]    y_ff, y_in;
   logic [MAG_W-1:0]    g_ff, g_in;
   logic [MAG_W-1:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]    q_ff, q_in;
   logic [MAG_W-1:0]    qn_ff, qn_in;
   status_type          stat_ff, stat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_neg_ff, rsp_neg_in;
   logic [MAG_IN-1:0]   rsp_num_ff, rsp_num_in;
   logic [MAG_IN-1:0]   rsp_den_ff, rsp_den_in;
   status_type          rsp_stat_ff, rsp_stat_in;

   // shared multiplier
   logic [IN_W-1:0]     mul_a, mul_b;
   logic [2*IN_W-1:0]   prod;
   // shared subtractor
   logic [MAG_W:0]      sub_a, sub_b;
   logic [MAG_W+1:0]    sub_res;
   logic                borrow;

   assign prod    = mul_a * mul_b;
   assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow  = sub_res[MAG_W+1];

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_neg = rsp_neg_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_status  = rsp_stat_ff;

   always_comb begin
      logic [IN_W-1:0]  a_mag, d_mag, s_mag;
      logic             a_sgn;
      logic [MAG_W-1:0] q_step;
      logic             ovf;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      dn_in        = dn_ff;
      bn_in        = bn_ff;
      num_neg_in   = num_neg_ff;
      nm_in        = nm_ff;
      dm_in        = dm_ff;
      sm_in        = sm_ff;
      bnum_in      = bnum_ff;
      bden_in      = bden_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      m2_in        = m2_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      g_in         = g_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      qn_in        = qn_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_neg_in   = rsp_neg_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_stat_in  = rsp_stat_ff;

      a_mag  = req_a_num[31] ? (~req_a_num + 32'd1) : req_a_num;
      d_mag  = req_a_den[31] ? (~req_a_den + 32'd1) : req_a_den;
      s_mag  = req_scalar[31] ? (~req_scalar + 32'd1) : req_scalar;
      a_sgn  = req_a_num[31] ^ req_a_neg;
      q_step = {q_ff[MAG_W-2:0], ~borrow};
      ovf    = (|(qn_ff >> (WORD_BITS - 1))) | (|(q_ff >> (WORD_BITS - 1)));

      mul_a = (cnt_ff == '0) ? nm_ff : dm_ff;
      case (cnt_ff[1:0])
         2'd0: begin
            case (op_ff)
               OP_MUL:  mul_b = {1'b0, bnum_ff};
               OP_ADD:  mul_b = {1'b0, bden_ff};
               default: mul_b = sm_ff;
            endcase
         end
         2'd1:    mul_b = {1'b0, bden_ff};
         default: mul_b = {1'b0, bnum_ff};
      endcase

      case (state_ff)
         S_COMBINE: begin
            sub_a = {1'b0, num_ff};
            sub_b = {1'b0, m2_ff};
         end
         S_DIVN, S_DIVD: begin
            sub_a = {rem_ff, q_ff[MAG_W-1]};
            sub_b = {1'b0, g_ff};
         end
         default: begin
            sub_a = {1'b0, x_ff};
            sub_b = {1'b0, y_ff};
         end
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_op;
               dn_in   = req_a_den[31];
               bn_in   = req_b_neg;
               nm_in   = a_mag;
               dm_in   = d_mag;
               sm_in   = s_mag;
               bnum_in = req_b_num;
               bden_in = req_b_den;
               num_in  = {{(MAG_W-IN_W){1'b0}}, a_mag};
               den_in  = {{(MAG_W-IN_W){1'b0}}, d_mag};
               cnt_in  = '0;
               case (req_op)
                  OP_NORM:  num_neg_in = req_a_num[31];
                  OP_MUL:   num_neg_in = a_sgn ^ req_b_neg;
                  OP_ADD:   num_neg_in = a_sgn;
                  default:  num_neg_in = a_sgn ^ req_scalar[31];
               endcase
               state_in = (req_op == OP_NORM) ? S_CHECK : S_MUL;
            end
         end
         S_MUL: begin
            case (cnt_ff[1:0])
               2'd0: begin
                  num_in = prod[MAG_W-1:0];
                  if (op_ff == OP_SCALE) begin
                     state_in = S_CHECK;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               2'd1: begin
                  den_in = prod[MAG_W-1:0];
                  if (op_ff == OP_MUL) begin
                     state_in = S_CHECK;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               default: begin
                  m2_in    = prod[MAG_W-1:0];
                  state_in = S_COMBINE;
               end
            endcase
         end
         S_COMBINE: begin
            // signed sum of the two cross products
            if (num_neg_ff == (dn_ff ^ bn_ff)) begin
               num_in = num_ff + m2_ff;
            end else if (!borrow) begin
               num_in = sub_res[MAG_W-1:0];
            end else begin
               num_in     = m2_ff - num_ff;
               num_neg_in = dn_ff ^ bn_ff;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            stat_in  = ST_OK;
            cnt_in   = '0;
            rem_in   = '0;
            if (den_ff == '0) begin
               stat_in  = ST_ZERO_DEN;
               qn_in    = '0;
               q_in     = '0;
               state_in = S_OUT;
            end else if (num_ff == '0) begin
               // 0/1 with a positive sign: cancel the denominator sign
               qn_in      = '0;
               q_in       = {{(MAG_W-1){1'b0}}, 1'b1};
               num_neg_in = dn_ff;
               state_in   = S_OUT;
            end else begin
               x_in     = num_ff;
               y_in     = den_ff;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // binary gcd; common factors of two come off num and den directly
            if (sub_res == '0) begin
               g_in     = x_ff;
               q_in     = num_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVN;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in   = x_ff >> 1;
               y_in   = y_ff >> 1;
               num_in = num_ff >> 1;
               den_in = den_ff >> 1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (borrow) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               x_in = sub_res[MAG_W-1:0];
            end
         end
         S_DIVN, S_DIVD: begin
            q_in = q_step;
            if (!borrow) begin
               rem_in = sub_res[MAG_W-1:0];
            end else begin
               rem_in = {rem_ff[MAG_W-2:0], q_ff[MAG_W-1]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in = '0;
               if (state_ff == S_DIVN) begin
                  qn_in    = q_step;
                  q_in     = den_ff;
                  rem_in   = '0;
                  state_in = S_DIVD;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (stat_ff == ST_OK && ovf) begin
                  rsp_stat_in = ST_OVERFLOW;
               end else begin
                  rsp_stat_in = stat_ff;
               end
               if (stat_ff == ST_OK && !ovf) begin
                  rsp_neg_in = num_neg_ff ^ dn_ff;
                  rsp_num_in = qn_ff[MAG_IN-1:0];
                  rsp_den_in = q_ff[MAG_IN-1:0];
               end else begin
                  rsp_neg_in = 1'b0;
                  rsp_num_in = '0;
                  rsp_den_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      dn_ff       <= dn_in;
      bn_ff       <= bn_in;
      num_neg_ff  <= num_neg_in;
      nm_ff       <= nm_in;
      dm_ff       <= dm_in;
      sm_ff       <= sm_in;
      bnum_ff     <= bnum_in;
      bden_ff     <= bden_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      m2_ff       <= m2_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      g_ff        <= g_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      qn_ff       <= qn_in;
      stat_ff     <= stat_in;
      rsp_neg_ff  <= rsp_neg_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result appeared outside the output step");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GCD |-> (x_ff != '0 && y_ff != '0))
      else $error("gcd operand reached zero");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVN || state_ff == S_DIVD) |-> rem_ff < g_ff)
      else $error("divider remainder not below divisor");

   a_err_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (!rsp_res_neg && rsp_res_num == '0 && rsp_res_den == '0))
      else $error("error status with nonzero payload");

   a_ok_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> rsp_res_den != '0)
      else $error("good result with zero denominator");

endmodule
